@@ sv/rpt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types, codes and constants of the relative pointer tracker.
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int ACCUM_BITS_DEF = 16;

  localparam int CFG_W  = 13;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int PT_W   = 13;

  localparam logic [1:0] CMD_MOTION     = 2'd0;
  localparam logic [1:0] CMD_CLICK      = 2'd1;
  localparam logic [1:0] CMD_POLL       = 2'd2;
  localparam logic [1:0] CMD_DISCONNECT = 2'd3;

  localparam logic [2:0] REG_ACTIVE_WIDTH    = 3'd0;
  localparam logic [2:0] REG_ACTIVE_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_PHYSICAL_WIDTH  = 3'd2;
  localparam logic [2:0] REG_PHYSICAL_HEIGHT = 3'd3;
  localparam logic [2:0] REG_ROTATION        = 3'd4;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam int SCREEN_W_DEF = 720;
  localparam int SCREEN_H_DEF = 1280;
  localparam int CURSOR_X_RST = 360;
  localparam int CURSOR_Y_RST = 640;
  localparam int PT_MIN       = -4096;
  localparam int PT_MAX       = 4095;

  typedef struct packed {
    logic [CFG_W-1:0] active_width;
    logic [CFG_W-1:0] active_height;
    logic [CFG_W-1:0] physical_width;
    logic [CFG_W-1:0] physical_height;
    logic [1:0]       rotation;
  } rpt_cfg_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_PRESS   = 3'b010,
    PH_RELEASE = 3'b100
  } click_phase_t;

endpackage

@@ sv/rpt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_req_if / rpt_res_if
// Valid/ready channels for tracker requests and poll results.
// ----------------------------------------------------------------------------
interface rpt_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [7:0] delta_x;
  logic signed [7:0] delta_y;
  logic              left_button;

  modport source (output valid, cmd, delta_x, delta_y, left_button, input ready);
  modport sink   (input valid, cmd, delta_x, delta_y, left_button, output ready);
endinterface

interface rpt_res_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] point_x;
  logic signed [12:0] point_y;
  logic               pressed;
  logic               read_again;
  logic               activity;
  logic               connected;

  modport source (output valid, point_x, point_y, pressed, read_again, activity,
                  connected, input ready);
  modport sink   (input valid, point_x, point_y, pressed, read_again, activity,
                  connected, output ready);
endinterface

@@ sv/rpt_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_regs
// APB register file: screen sizes and rotation.
// ----------------------------------------------------------------------------
module rpt_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rpt_pkg::ADDR_W-1:0] paddr,
  input  logic [rpt_pkg::DATA_W-1:0] pwdata,
  output logic [rpt_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output rpt_pkg::rpt_cfg_t         cfg
);
  import rpt_pkg::*;

  logic [2:0] index;
  logic       wr;

  assign index  = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_width    <= CFG_W'(SCREEN_W_DEF);
      cfg.active_height   <= CFG_W'(SCREEN_H_DEF);
      cfg.physical_width  <= CFG_W'(SCREEN_W_DEF);
      cfg.physical_height <= CFG_W'(SCREEN_H_DEF);
      cfg.rotation        <= ROT_0;
    end else if (wr) begin
      case (index)
        REG_ACTIVE_WIDTH:    cfg.active_width    <= pwdata[CFG_W-1:0];
        REG_ACTIVE_HEIGHT:   cfg.active_height   <= pwdata[CFG_W-1:0];
        REG_PHYSICAL_WIDTH:  cfg.physical_width  <= pwdata[CFG_W-1:0];
        REG_PHYSICAL_HEIGHT: cfg.physical_height <= pwdata[CFG_W-1:0];
        REG_ROTATION:        cfg.rotation        <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_ACTIVE_WIDTH:    prdata = DATA_W'(cfg.active_width);
      REG_ACTIVE_HEIGHT:   prdata = DATA_W'(cfg.active_height);
      REG_PHYSICAL_WIDTH:  prdata = DATA_W'(cfg.physical_width);
      REG_PHYSICAL_HEIGHT: prdata = DATA_W'(cfg.physical_height);
      REG_ROTATION:        prdata = DATA_W'(cfg.rotation);
      default:             prdata = '0;
    endcase
  end

endmodule

@@ sv/rpt_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_map
// Maps the active-screen cursor to physical panel coordinates by rotation.
// ----------------------------------------------------------------------------
module rpt_map #(
  parameter int CUR_W = 12
) (
  input  logic [CUR_W-1:0]               cur_x,
  input  logic [CUR_W-1:0]               cur_y,
  input  rpt_pkg::rpt_cfg_t              cfg,
  output logic signed [rpt_pkg::PT_W-1:0] point_x,
  output logic signed [rpt_pkg::PT_W-1:0] point_y
);
  import rpt_pkg::*;

  localparam int RW = ((CUR_W > CFG_W) ? CUR_W : CFG_W) + 2;

  logic signed [RW-1:0] ax, ay, ow, oh, px, py;

  function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [RW-1:0] v);
    if (v < RW'(PT_MIN)) begin
      return PT_W'(PT_MIN);
    end else if (v > RW'(PT_MAX)) begin
      return PT_W'(PT_MAX);
    end
    return PT_W'(v);
  endfunction

  always_comb begin
    ax = RW'(signed'({1'b0, cur_x}));
    ay = RW'(signed'({1'b0, cur_y}));
    ow = (cfg.physical_width == '0) ? RW'(SCREEN_W_DEF)
                                     : RW'(signed'({1'b0, cfg.physical_width}));
    oh = (cfg.physical_height == '0) ? RW'(SCREEN_H_DEF)
                                      : RW'(signed'({1'b0, cfg.physical_height}));
    case (cfg.rotation)
      ROT_90: begin
        px = ay;
        py = oh - ax - RW'(1);
      end
      ROT_180: begin
        px = ow - ax - RW'(1);
        py = oh - ay - RW'(1);
      end
      ROT_270: begin
        px = ow - ay - RW'(1);
        py = ax;
      end
      default: begin
        px = ax;
        py = ay;
      end
    endcase
  end

  assign point_x = sat_pt(px);
  assign point_y = sat_pt(py);

endmodule

@@ sv/relative_pointer_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relative_pointer_tracker
// Relative mouse tracker: accumulates motion, applies it on poll, clamps to the
// active screen and reports rotated physical coordinates and pointer state.
//
//   channel   dir  handshake        moves
//   request   in   valid/ready      cmd, delta_x, delta_y, left_button
//   result    out  valid/ready      point_x, point_y, pressed, read_again,
//                                   activity, connected (polls only)
//   apb       in   psel/penable     register writes and reads, pready tied high
//
// One request per cycle while request.ready is high; state updates at the accepting edge.
// A poll result is loaded into the output register at the accepting edge.
// request.ready is low only while a result is held and result.ready is low.
// Synchronous reset restores registers, accumulators, cursor (360, 640), link.
// ----------------------------------------------------------------------------
module relative_pointer_tracker #(
  parameter int COORD_BITS = rpt_pkg::COORD_BITS_DEF,
  parameter int ACCUM_BITS = rpt_pkg::ACCUM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  rpt_req_if.sink                     request,
  rpt_res_if.source                   result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpt_pkg::ADDR_W-1:0]  paddr,
  input  logic [rpt_pkg::DATA_W-1:0]  pwdata,
  output logic [rpt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import rpt_pkg::*;

  localparam int CUR_W = (COORD_BITS > 10) ? COORD_BITS : 10;
  localparam int M1    = (CUR_W > ACCUM_BITS) ? CUR_W : ACCUM_BITS;
  localparam int SW    = ((M1 > CFG_W) ? M1 : CFG_W) + 2;

  rpt_cfg_t cfg;

  logic signed [ACCUM_BITS-1:0] accum_x, accum_y, accum_x_next, accum_y_next;
  logic                         button_held, button_held_next;
  logic                         click_waiting, click_waiting_next;
  logic                         link_up, link_up_next;
  click_phase_t                 phase, phase_next, phase_eff;
  logic [CUR_W-1:0]             cursor_x, cursor_y, cursor_x_next, cursor_y_next;
  logic [CUR_W-1:0]             move_x, move_y;
  logic signed [PT_W-1:0]       map_x, map_y;
  logic                         acc, poll, pressed_c, cont_c, act_c;

  rpt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  function automatic logic signed [ACCUM_BITS-1:0] sat_add(
    input logic signed [ACCUM_BITS-1:0] a,
    input logic signed [7:0]            d
  );
    logic signed [ACCUM_BITS:0] s;
    s = (ACCUM_BITS+1)'(a) + (ACCUM_BITS+1)'(d);
    if (s[ACCUM_BITS] != s[ACCUM_BITS-1]) begin
      return {s[ACCUM_BITS], {(ACCUM_BITS-1){~s[ACCUM_BITS]}}};
    end
    return s[ACCUM_BITS-1:0];
  endfunction

  function automatic logic [CUR_W-1:0] cur_move(
    input logic [CUR_W-1:0]             c,
    input logic signed [ACCUM_BITS-1:0] d,
    input logic [CFG_W-1:0]             size
  );
    logic signed [SW-1:0] s, sz, lim, top;
    s   = SW'(signed'({1'b0, c})) + SW'(d);
    sz  = SW'(signed'({1'b0, size}));
    lim = SW'(1) <<< COORD_BITS;
    top = (sz < lim) ? sz : lim;
    if (top == '0 || s < SW'(0)) begin
      return '0;
    end else if (s > top - SW'(1)) begin
      return CUR_W'(top - SW'(1));
    end
    return CUR_W'(s);
  endfunction

  assign move_x = cur_move(cursor_x, accum_x, cfg.active_width);
  assign move_y = cur_move(cursor_y, accum_y, cfg.active_height);

  rpt_map #(.CUR_W(CUR_W)) u_map (
    .cur_x   (move_x),
    .cur_y   (move_y),
    .cfg     (cfg),
    .point_x (map_x),
    .point_y (map_y)
  );

  assign request.ready = !result.valid || result.ready;
  assign acc  = request.valid && request.ready;
  assign poll = acc && (request.cmd == CMD_POLL);

  always_comb begin
    phase_eff = (click_waiting && phase == PH_IDLE) ? PH_PRESS : phase;
    act_c     = (accum_x != '0) || (accum_y != '0) || button_held || click_waiting;
    case (phase_eff)
      PH_PRESS: begin
        pressed_c  = 1'b1;
        cont_c     = 1'b1;
        phase_next = PH_RELEASE;
      end
      PH_RELEASE: begin
        pressed_c  = 1'b0;
        cont_c     = 1'b0;
        phase_next = PH_IDLE;
      end
      default: begin
        pressed_c  = button_held;
        cont_c     = 1'b0;
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    accum_x_next       = accum_x;
    accum_y_next       = accum_y;
    button_held_next   = button_held;
    click_waiting_next = click_waiting;
    link_up_next       = link_up;
    cursor_x_next      = cursor_x;
    cursor_y_next      = cursor_y;
    case (request.cmd)
      CMD_MOTION: begin
        accum_x_next     = sat_add(accum_x, request.delta_x);
        accum_y_next     = sat_add(accum_y, request.delta_y);
        button_held_next = request.left_button;
        link_up_next     = 1'b1;
      end
      CMD_CLICK: begin
        click_waiting_next = 1'b1;
        link_up_next       = 1'b1;
      end
      CMD_POLL: begin
        accum_x_next       = '0;
        accum_y_next       = '0;
        click_waiting_next = 1'b0;
        cursor_x_next      = move_x;
        cursor_y_next      = move_y;
      end
      default: begin
        accum_x_next     = '0;
        accum_y_next     = '0;
        button_held_next = 1'b0;
        link_up_next     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum_x       <= '0;
      accum_y       <= '0;
      button_held   <= 1'b0;
      click_waiting <= 1'b0;
      link_up       <= 1'b0;
      phase         <= PH_IDLE;
      cursor_x      <= CUR_W'(CURSOR_X_RST);
      cursor_y      <= CUR_W'(CURSOR_Y_RST);
      result.valid  <= 1'b0;
    end else begin
      if (acc) begin
        accum_x       <= accum_x_next;
        accum_y       <= accum_y_next;
        button_held   <= button_held_next;
        click_waiting <= click_waiting_next;
        link_up       <= link_up_next;
        cursor_x      <= cursor_x_next;
        cursor_y      <= cursor_y_next;
      end
      if (poll) begin
        phase <= phase_next;
      end
      if (poll) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (poll) begin
      result.point_x    <= map_x;
      result.point_y    <= map_y;
      result.pressed    <= pressed_c;
      result.read_again <= cont_c;
      result.activity   <= act_c;
      result.connected  <= link_up;
    end
  end

  a_poll_gives_result: assert property (@(posedge clk) disable iff (rst)
    poll |=> result.valid)
    else $error("accepted poll produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    acc && (request.cmd != CMD_POLL) && result.ready |=> !result.valid)
    else $error("result raised without a poll");

  a_cont_implies_pressed: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.read_again |-> result.pressed)
    else $error("read_again without pressed");

  a_disconnect_clears: assert property (@(posedge clk) disable iff (rst)
    acc && (request.cmd == CMD_DISCONNECT) |=>
      (accum_x == '0) && (accum_y == '0) && !button_held && !link_up)
    else $error("disconnect left state behind");

  a_press_then_release: assert property (@(posedge clk) disable iff (rst)
    poll && cont_c |=> phase == PH_RELEASE)
    else $error("press phase not followed by release");

endmodule
